[src/crch_pkg.sv]
// Package for the closest ray-circle hit block: widths, register indexes
// and the request type of the shared serial multiplier.
// No dependencies; used by every module in src.
package crch_pkg;

   localparam int COORD_W  = 16;
   localparam int OUT_W    = COORD_W + 1;
   localparam int ENT_W    = 16;
   localparam int RADIN_W  = COORD_W - 1;
   localparam int DIR_W    = 16;
   localparam int SQ_W     = 32;
   localparam int CSR_W    = 16;
   localparam int CSR_A_W  = 3;

   localparam int MUL_W    = 22;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int MUL_CNT_W = $clog2(MUL_W);
   localparam int RAD_W    = 38;
   localparam int ROOT_W   = RAD_W / 2;
   localparam int ROOT_CNT_W = $clog2(ROOT_W);

   localparam int REQ_DATA_W = ((ENT_W + 2 * COORD_W + RADIN_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * OUT_W + SQ_W + ENT_W + 7) / 8) * 8;

   localparam logic [CSR_A_W-1:0] REG_ORIGIN_X   = 3'd0;
   localparam logic [CSR_A_W-1:0] REG_ORIGIN_Y   = 3'd1;
   localparam logic [CSR_A_W-1:0] REG_DIR_X      = 3'd2;
   localparam logic [CSR_A_W-1:0] REG_DIR_Y      = 3'd3;
   localparam logic [CSR_A_W-1:0] REG_MAX_DIST   = 3'd4;
   localparam logic [CSR_A_W-1:0] REG_EXCL_EN    = 3'd5;
   localparam logic [CSR_A_W-1:0] REG_EXCL_ID    = 3'd6;

   typedef struct packed {
      logic                    start;
      logic signed [MUL_W-1:0] a;
      logic signed [MUL_W-1:0] b;
   } mul_req_type;

endpackage

[src/crch_mul.sv]
// Serial signed multiplier: one bit of the multiplier per cycle on magnitudes,
// sign applied in a final step. Depends on crch_pkg.
module crch_mul (
   input  logic                                 clock,
   input  logic                                 reset,
   input  crch_pkg::mul_req_type                req,
   output logic                                 done,
   output logic signed [crch_pkg::PROD_W-1:0]   prod
);
   logic                                busy_ff, busy_in;
   logic                                fix_ff, fix_in;
   logic                                done_ff, done_in;
   logic [crch_pkg::MUL_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                                neg_ff, neg_in;
   logic [crch_pkg::MUL_W-1:0]          amag_ff, amag_in;
   logic [crch_pkg::MUL_W-1:0]          bsh_ff, bsh_in;
   logic [crch_pkg::MUL_W-1:0]          hi_ff, hi_in;
   logic [crch_pkg::MUL_W-1:0]          lo_ff, lo_in;
   logic signed [crch_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [crch_pkg::MUL_W:0]            sum;
   logic [crch_pkg::PROD_W-1:0]         mag;

   always_comb begin
      busy_in = busy_ff;
      fix_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      amag_in = amag_ff;
      bsh_in  = bsh_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      prod_in = prod_ff;
      sum     = {1'b0, hi_ff} + (bsh_ff[0] ? {1'b0, amag_ff} : '0);
      mag     = {hi_ff, lo_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = req.a[crch_pkg::MUL_W-1] ^ req.b[crch_pkg::MUL_W-1];
         amag_in = req.a[crch_pkg::MUL_W-1] ? -req.a : req.a;
         bsh_in  = req.b[crch_pkg::MUL_W-1] ? -req.b : req.b;
         hi_in   = '0;
         lo_in   = '0;
      end else if (busy_ff) begin
         hi_in  = sum[crch_pkg::MUL_W:1];
         lo_in  = {sum[0], lo_ff[crch_pkg::MUL_W-1:1]};
         bsh_in = bsh_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == crch_pkg::MUL_CNT_W'(crch_pkg::MUL_W - 1)) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end else if (fix_ff) begin
         prod_in = neg_ff ? -$signed(mag) : $signed(mag);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      amag_ff <= amag_in;
      bsh_ff  <= bsh_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;
endmodule

[src/crch_isqrt.sv]
// Integer square root, two radicand bits per cycle (restoring method).
// Depends on crch_pkg.
module crch_isqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [crch_pkg::RAD_W-1:0]       radicand,
   output logic                             done,
   output logic [crch_pkg::ROOT_W-1:0]      root
);
   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [crch_pkg::ROOT_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [crch_pkg::RAD_W-1:0]         rad_ff, rad_in;
   logic [crch_pkg::ROOT_W+3:0]        rem_ff, rem_in;
   logic [crch_pkg::ROOT_W-1:0]        root_ff, root_in;
   logic [crch_pkg::ROOT_W+3:0]        rem_sh;
   logic [crch_pkg::ROOT_W+3:0]        trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rem_sh  = {rem_ff[crch_pkg::ROOT_W+1:0], rad_ff[crch_pkg::RAD_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         cnt_in = cnt_ff + 1'b1;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[crch_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[crch_pkg::ROOT_W-2:0], 1'b0};
         end
         if (cnt_ff == crch_pkg::ROOT_CNT_W'(crch_pkg::ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

[src/closest_ray_circle_hit.sv]
// Top level of the closest ray-circle hit block: registers, sequencer,
// nearest-hit tracking and the result register.
// Depends on crch_pkg, crch_mul and crch_isqrt.
//
// Software writes the ray through the csr_ port (csr_we, csr_addr, csr_wdata)
// while the block is idle. Circles then arrive on the req_ stream: tdata holds
// entity id, centre x, centre y and radius, tlast marks the last circle of a
// raycast. Each circle is worked through by one shared serial multiplier
// and a square root unit. A full circle takes eleven products and one root;
// a skipped circle goes straight to the finish step and a rejected one takes
// fewer products. req_tready is high only between circles. On the last
// circle the nearest hit is loaded into the rsp_ register from the finish
// step once the work ends; if an earlier result is still waiting because
// rsp_tready is low, the block holds until it is taken. tuser carries the
// hit flag. Reset is synchronous and restores the default ray and an empty
// raycast.
module closest_ray_circle_hit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // entity_id, center_x, center_y, radius, zero pad
   input  logic [crch_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // hit_x, hit_y, hit_sq_distance, hit_entity, zero pad
   output logic [crch_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // hit
   output logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [crch_pkg::CSR_A_W-1:0]        csr_addr,
   input  logic [crch_pkg::CSR_W-1:0]          csr_wdata
);
   localparam int MW = crch_pkg::MUL_W;
   localparam int PW = crch_pkg::PROD_W;

   typedef enum logic [1:0] {S_IDLE, S_MUL, S_SQRT, S_FIN} state_type;
   typedef enum logic [3:0] {
      OP_MDX, OP_MDY, OP_MXX, OP_MYY, OP_RR, OP_BB,
      OP_TDX, OP_TDY, OP_OXX, OP_OYY, OP_MDMD
   } op_type;

   // Configuration registers
   logic signed [crch_pkg::COORD_W-1:0] org_x_ff, org_y_ff;
   logic signed [crch_pkg::DIR_W-1:0]   dir_x_ff, dir_y_ff;
   logic [crch_pkg::COORD_W-1:0]        max_dist_ff;
   logic                                excl_en_ff;
   logic [crch_pkg::ENT_W-1:0]          excl_id_ff;

   // Sequencer state
   state_type                    state_ff;
   op_type                       op_ff;
   logic                         launch_ff;
   logic                         sqrt_go_ff;
   logic                         last_ff;
   logic [crch_pkg::ENT_W-1:0]   ent_ff;
   logic signed [MW-1:0]         mx_ff, my_ff, r_ff;
   logic signed [PW-1:0]         acc_ff;
   logic signed [PW-1:0]         c_ff;
   logic signed [MW-1:0]         b_ff;
   logic [crch_pkg::RAD_W-1:0]   disc_ff;
   logic signed [MW-1:0]         t_ff;
   logic signed [MW-1:0]         offx_ff, offy_ff;

   // Nearest hit so far
   logic                         best_valid_ff;
   logic signed [crch_pkg::OUT_W-1:0] best_x_ff, best_y_ff;
   logic [crch_pkg::SQ_W-1:0]    best_sq_ff;
   logic [crch_pkg::ENT_W-1:0]   best_ent_ff;

   // Result register
   logic                         rsp_valid_ff;
   logic                         rsp_hit_ff;
   logic [crch_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   crch_pkg::mul_req_type        mreq;
   logic                         mul_done;
   logic signed [PW-1:0]         prod;
   logic                         sqrt_done;
   logic [crch_pkg::ROOT_W-1:0]  root;

   logic                         req_acc;
   logic signed [PW-1:0]         sum_p;
   logic signed [PW-1:0]         rnd;
   logic signed [PW-1:0]         diff_p;
   logic signed [MW-1:0]         t_raw;
   logic signed [MW-1:0]         hx, hy;
   logic signed [crch_pkg::OUT_W-1:0] sat_x, sat_y;
   logic                         emit_ok;

   crch_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .done  (mul_done),
      .prod  (prod)
   );

   crch_isqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_go_ff),
      .radicand (disc_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign emit_ok    = !rsp_valid_ff || rsp_tready;

   always_comb begin
      mreq.start = launch_ff;
      mreq.a     = mx_ff;
      mreq.b     = MW'(dir_x_ff);
      unique case (op_ff)
         OP_MDX:  begin mreq.a = mx_ff;   mreq.b = MW'(dir_x_ff); end
         OP_MDY:  begin mreq.a = my_ff;   mreq.b = MW'(dir_y_ff); end
         OP_MXX:  begin mreq.a = mx_ff;   mreq.b = mx_ff;         end
         OP_MYY:  begin mreq.a = my_ff;   mreq.b = my_ff;         end
         OP_RR:   begin mreq.a = r_ff;    mreq.b = r_ff;          end
         OP_BB:   begin mreq.a = b_ff;    mreq.b = b_ff;          end
         OP_TDX:  begin mreq.a = t_ff;    mreq.b = MW'(dir_x_ff); end
         OP_TDY:  begin mreq.a = t_ff;    mreq.b = MW'(dir_y_ff); end
         OP_OXX:  begin mreq.a = offx_ff; mreq.b = offx_ff;       end
         OP_OYY:  begin mreq.a = offy_ff; mreq.b = offy_ff;       end
         OP_MDMD: begin
            mreq.a = MW'({1'b0, max_dist_ff});
            mreq.b = MW'({1'b0, max_dist_ff});
         end
         default: begin mreq.a = mx_ff;   mreq.b = mx_ff;         end
      endcase
   end

   always_comb begin
      // acc_ff holds the first half of a two-term sum, or zero for a single term.
      sum_p  = acc_ff + prod;
      rnd    = (sum_p + PW'(8192)) >>> 14;
      diff_p = c_ff - prod;
      t_raw  = -b_ff - MW'({1'b0, root});
      hx     = MW'(org_x_ff) + offx_ff;
      hy     = MW'(org_y_ff) + offy_ff;
      if (hx > MW'(65535))       sat_x = 17'sd65535;
      else if (hx < -MW'(65536)) sat_x = -17'sd65536;
      else                       sat_x = hx[crch_pkg::OUT_W-1:0];
      if (hy > MW'(65535))       sat_y = 17'sd65535;
      else if (hy < -MW'(65536)) sat_y = -17'sd65536;
      else                       sat_y = hy[crch_pkg::OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff    <= '0;
         org_y_ff    <= '0;
         dir_x_ff    <= 16'sd16384;
         dir_y_ff    <= '0;
         max_dist_ff <= '1;
         excl_en_ff  <= 1'b0;
         excl_id_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            crch_pkg::REG_ORIGIN_X: org_x_ff    <= csr_wdata;
            crch_pkg::REG_ORIGIN_Y: org_y_ff    <= csr_wdata;
            crch_pkg::REG_DIR_X:    dir_x_ff    <= csr_wdata;
            crch_pkg::REG_DIR_Y:    dir_y_ff    <= csr_wdata;
            crch_pkg::REG_MAX_DIST: max_dist_ff <= csr_wdata;
            crch_pkg::REG_EXCL_EN:  excl_en_ff  <= csr_wdata[0];
            crch_pkg::REG_EXCL_ID:  excl_id_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         op_ff         <= OP_MDX;
         launch_ff     <= 1'b0;
         sqrt_go_ff    <= 1'b0;
         best_valid_ff <= 1'b0;
         best_sq_ff    <= '1;
         best_x_ff     <= '0;
         best_y_ff     <= '0;
         best_ent_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         launch_ff  <= 1'b0;
         sqrt_go_ff <= 1'b0;
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  ent_ff  <= req_tdata[15:0];
                  mx_ff   <= MW'(org_x_ff) - MW'($signed(req_tdata[31:16]));
                  my_ff   <= MW'(org_y_ff) - MW'($signed(req_tdata[47:32]));
                  r_ff    <= MW'({1'b0, req_tdata[62:48]});
                  last_ff <= req_tlast;
                  acc_ff  <= '0;
                  op_ff   <= OP_MDX;
                  if (excl_en_ff && req_tdata[15:0] == excl_id_ff) begin
                     state_ff <= S_FIN;
                  end else begin
                     state_ff  <= S_MUL;
                     launch_ff <= 1'b1;
                  end
               end
            end
            S_MUL: begin
               if (mul_done) begin
                  launch_ff <= 1'b1;
                  acc_ff    <= '0;
                  unique case (op_ff)
                     OP_MDX: begin acc_ff <= prod; op_ff <= OP_MDY; end
                     OP_MDY: begin b_ff <= rnd[MW-1:0]; op_ff <= OP_MXX; end
                     OP_MXX: begin acc_ff <= prod; op_ff <= OP_MYY; end
                     OP_MYY: begin c_ff <= sum_p; op_ff <= OP_RR; end
                     OP_RR: begin
                        c_ff <= diff_p;
                        op_ff <= OP_BB;
                        // Outside the circle and heading away from it.
                        if (diff_p > 0 && b_ff > 0) begin
                           launch_ff <= 1'b0;
                           state_ff  <= S_FIN;
                        end
                     end
                     OP_BB: begin
                        launch_ff <= 1'b0;
                        if (prod < c_ff) begin
                           state_ff <= S_FIN;
                        end else begin
                           disc_ff    <= crch_pkg::RAD_W'(prod - c_ff);
                           sqrt_go_ff <= 1'b1;
                           state_ff   <= S_SQRT;
                        end
                     end
                     OP_TDX: begin offx_ff <= rnd[MW-1:0]; op_ff <= OP_TDY; end
                     OP_TDY: begin offy_ff <= rnd[MW-1:0]; op_ff <= OP_OXX; end
                     OP_OXX: begin acc_ff <= prod; op_ff <= OP_OYY; end
                     OP_OYY: begin acc_ff <= sum_p; op_ff <= OP_MDMD; end
                     OP_MDMD: begin
                        launch_ff <= 1'b0;
                        state_ff  <= S_FIN;
                        acc_ff    <= acc_ff;
                        if (acc_ff <= prod && acc_ff < PW'(best_sq_ff)) begin
                           best_valid_ff <= 1'b1;
                           best_sq_ff    <= acc_ff[crch_pkg::SQ_W-1:0];
                           best_x_ff     <= sat_x;
                           best_y_ff     <= sat_y;
                           best_ent_ff   <= ent_ff;
                        end
                     end
                     default: state_ff <= S_FIN;
                  endcase
               end
            end
            S_SQRT: begin
               if (sqrt_done) begin
                  t_ff      <= t_raw[MW-1] ? '0 : t_raw;
                  acc_ff    <= '0;
                  op_ff     <= OP_TDX;
                  launch_ff <= 1'b1;
                  state_ff  <= S_MUL;
               end
            end
            S_FIN: begin
               if (!last_ff) begin
                  state_ff <= S_IDLE;
               end else if (emit_ok) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_hit_ff    <= best_valid_ff;
                  rsp_data_ff   <= crch_pkg::RSP_DATA_W'({best_ent_ff, best_sq_ff,
                                                           best_y_ff, best_x_ff});
                  best_valid_ff <= 1'b0;
                  best_sq_ff    <= '1;
                  best_x_ff     <= '0;
                  best_y_ff     <= '0;
                  best_ent_ff   <= '0;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

   a_mul_only_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == S_MUL)
      else $error("product delivered outside a multiply step");

   a_sqrt_only_in_sqrt: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> state_ff == S_SQRT)
      else $error("root delivered outside the root step");

   a_empty_best: assert property (@(posedge clock) disable iff (reset)
      !best_valid_ff |-> best_sq_ff == '1)
      else $error("empty raycast holds a distance");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !$rose(rsp_valid_ff))
      else $error("result raised in the cycle after an item was taken");
endmodule

[tb/tb_closest_ray_circle_hit.sv]
// Self-checking testbench for closest_ray_circle_hit: drives circles on the
// req_ stream, predicts the nearest hit per raycast and checks rsp_ items.
// Depends on crch_pkg and the RTL in src.
module tb_closest_ray_circle_hit;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                       hit;
      logic [crch_pkg::OUT_W-1:0] x;
      logic [crch_pkg::OUT_W-1:0] y;
      logic [crch_pkg::SQ_W-1:0]  sq;
      logic [crch_pkg::ENT_W-1:0] ent;
   } hit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [crch_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [crch_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we = 1'b0;
   logic [crch_pkg::CSR_A_W-1:0] csr_addr = '0;
   logic [crch_pkg::CSR_W-1:0] csr_wdata = '0;

   // Ray settings and running nearest hit held by the predictor.
   logic signed [15:0] ray_ox, ray_oy, ray_dx, ray_dy;
   logic [15:0] ray_maxd, ray_excl_id;
   logic ray_excl_en;
   hit_type nearest;
   hit_type hits_due[$];
   int errors = 0;
   int results_seen = 0;
   int hold_off = 0;
   int rsp_wait = 0;
   int items_sent = 0;
   // The sender toggles hold_ask; the receiver starts a long stall on each change.
   logic hold_ask = 1'b0;
   logic hold_seen = 1'b0;

   closest_ray_circle_hit uut (.*);

   always #5 clock = ~clock;

   function automatic longint floor_q14(longint v);
      longint w;
      w = v + 8192;
      if (w >= 0) return w >>> 14;
      return -(((-w) - 1) >>> 14) - 1;
   endfunction

   function automatic longint root_floor(longint v);
      longint lo, hi, mid;
      lo = 0;
      hi = 64'd3037000499;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (mid * mid <= v) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic longint clamp_coord(longint v);
      if (v > 65535) return 65535;
      if (v < -65536) return -65536;
      return v;
   endfunction

   function automatic void clear_nearest();
      nearest = '{hit: 1'b0, x: '0, y: '0, sq: '1, ent: '0};
   endfunction

   function automatic void test_circle(logic [15:0] id, logic signed [15:0] cx,
                                       logic signed [15:0] cy, logic [14:0] r);
      longint mx, my, b, c, disc, t, offx, offy, sq, md;
      mx = longint'(ray_ox) - cx;
      my = longint'(ray_oy) - cy;
      b = floor_q14(mx * ray_dx + my * ray_dy);
      c = mx * mx + my * my - longint'(r) * r;
      if (c > 0 && b > 0) return;
      disc = b * b - c;
      if (disc < 0) return;
      t = -b - root_floor(disc);
      if (t < 0) t = 0;
      offx = floor_q14(t * ray_dx);
      offy = floor_q14(t * ray_dy);
      sq = offx * offx + offy * offy;
      md = ray_maxd;
      if (sq > md * md) return;
      if (sq < longint'(nearest.sq)) begin
         nearest.hit = 1'b1;
         nearest.sq = sq[31:0];
         nearest.x = crch_pkg::OUT_W'(clamp_coord(ray_ox + offx));
         nearest.y = crch_pkg::OUT_W'(clamp_coord(ray_oy + offy));
         nearest.ent = id;
      end
   endfunction

   task automatic write_reg(logic [crch_pkg::CSR_A_W-1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         crch_pkg::REG_ORIGIN_X: ray_ox = val;
         crch_pkg::REG_ORIGIN_Y: ray_oy = val;
         crch_pkg::REG_DIR_X:    ray_dx = val;
         crch_pkg::REG_DIR_Y:    ray_dy = val;
         crch_pkg::REG_MAX_DIST: ray_maxd = val;
         crch_pkg::REG_EXCL_EN:  ray_excl_en = val[0];
         crch_pkg::REG_EXCL_ID:  ray_excl_id = val;
         default: ;
      endcase
   endtask

   // Waits for every due result, then lets a skipped circle finish.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (hits_due.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic set_ray(logic [15:0] ox, logic [15:0] oy, logic [15:0] dx,
                          logic [15:0] dy, logic [15:0] md, logic en,
                          logic [15:0] id);
      wait_idle();
      write_reg(crch_pkg::REG_ORIGIN_X, ox);
      write_reg(crch_pkg::REG_ORIGIN_Y, oy);
      write_reg(crch_pkg::REG_DIR_X, dx);
      write_reg(crch_pkg::REG_DIR_Y, dy);
      write_reg(crch_pkg::REG_MAX_DIST, md);
      write_reg(crch_pkg::REG_EXCL_EN, {15'd0, en});
      write_reg(crch_pkg::REG_EXCL_ID, id);
   endtask

   // The valid line stays high after an item when the next one follows at once.
   task automatic send_circle(logic [15:0] id, logic [15:0] cx, logic [15:0] cy,
                              logic [14:0] r, logic last_flag);
      int gap;
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= crch_pkg::REQ_DATA_W'({r, cy, cx, id});
      req_tlast <= last_flag;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!(ray_excl_en && id == ray_excl_id)) test_circle(id, cx, cy, r);
      if (last_flag) begin
         hits_due.push_back(nearest);
         clear_nearest();
      end
      items_sent++;
   endtask

   // Circles mostly placed near the ray so that hits are common.
   task automatic random_circle(logic last_flag);
      logic signed [15:0] cx, cy;
      int k;
      k = $urandom_range(0, 9);
      if (k < 7) begin
         cx = ray_ox + $signed(16'($urandom_range(0, 4000)) - 16'd2000);
         cy = ray_oy + $signed(16'($urandom_range(0, 4000)) - 16'd2000);
         send_circle(16'($urandom_range(0, 7)), cx, cy, 15'($urandom_range(0, 2500)),
                     last_flag);
      end else begin
         send_circle(16'($urandom), 16'($urandom), 16'($urandom), 15'($urandom),
                     last_flag);
      end
   endtask

   task automatic random_ray();
      logic signed [15:0] dx, dy;
      int a;
      a = $urandom_range(0, 3);
      case (a)
         0: begin dx = 16'sd16384; dy = 16'sd0; end
         1: begin dx = 16'sd0; dy = -16'sd16384; end
         2: begin dx = 16'sd11585; dy = 16'sd11585; end
         default: begin
            dx = 16'($urandom_range(0, 32768) - 16384);
            dy = 16'($urandom);
         end
      endcase
      set_ray(16'($urandom_range(0, 8000) - 4000), 16'($urandom_range(0, 8000) - 4000),
              dx, dy,
              $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 5000)),
              1'($urandom_range(0, 1)), 16'($urandom_range(0, 7)));
   endtask

   task automatic test_directed();
      // Default ray: along +x from the origin.
      send_circle(16'd1, 16'd800, 16'd0, 15'd160, 1'b1);       // plain hit
      send_circle(16'd2, 16'd800, 16'd800, 15'd16, 1'b1);      // negative discriminant
      send_circle(16'd3, -16'sd800, 16'd0, 15'd160, 1'b1);     // behind, pointing away
      send_circle(16'd4, 16'd10, 16'd0, 15'd320, 1'b1);        // origin inside
      send_circle(16'hFFFF, 16'h7FFF, 16'h7FFF, 15'h7FFF, 1'b0);
      send_circle(16'd0, 16'h8000, 16'h8000, 15'd0, 1'b0);
      send_circle(16'd5, 16'd400, 16'd0, 15'd16, 1'b0);
      send_circle(16'd6, 16'd200, 16'd0, 15'd16, 1'b1);        // nearer replaces
      set_ray(16'h7FFF, 16'h7FFF, 16'd16384, 16'd16384, 16'hFFFF, 1'b1, 16'd9);
      send_circle(16'd9, 16'h7FFF, 16'h7FFF, 15'd100, 1'b1);   // excluded, still emits
      send_circle(16'd8, 16'h7FFF, 16'h7FFF, 15'h7FFF, 1'b1);  // origin inside, hit at the origin
      set_ray(16'h8000, 16'h8000, -16'sd16384, 16'h8000, 16'd0, 1'b0, 16'hFFFF);
      send_circle(16'hFFFF, 16'h8000, 16'h8000, 15'd50, 1'b1);
      send_circle(16'd7, 16'd0, 16'd0, 15'h7FFF, 1'b1);
      set_ray(16'd0, 16'd0, 16'd0, -16'sd16384, 16'd100, 1'b1, 16'hFFFF);
      send_circle(16'd3, 16'd0, -16'sd800, 15'd160, 1'b1);     // beyond max distance
      send_circle(16'd3, 16'd0, -16'sd80, 15'd16, 1'b1);
   endtask

   task automatic test_random();
      int n;
      for (int s = 0; s < 65; s++) begin
         random_ray();
         n = $urandom_range(1, 30);
         for (int i = 0; i < n; i++) random_circle(i == n - 1 || $urandom_range(0, 5) == 0);
      end
   endtask

   task automatic test_backpressure();
      // Receiver stalls while circles keep coming; then the sender waits.
      hold_ask <= ~hold_ask;
      for (int i = 0; i < 20; i++) random_circle(1'($urandom_range(0, 1)));
      random_circle(1'b1);
      req_tvalid <= 1'b0;
      while (hits_due.size() != 0) @(posedge clock);
      for (int i = 0; i < 10; i++) random_circle(1'b1);
   endtask

   // Receiver: after each taken item it waits a drawn number of cycles.
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_off <= 0;
         hold_seen <= 1'b0;
         rsp_wait <= 0;
      end else if (hold_ask != hold_seen) begin
         hold_seen <= hold_ask;
         hold_off <= 3000;
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         n = $urandom_range(0, 4);
         rsp_wait <= n;
         rsp_tready <= (n == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_tready <= (rsp_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      hit_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{hit: rsp_tuser, x: rsp_tdata[16:0], y: rsp_tdata[33:17],
                 sq: rsp_tdata[65:34], ent: rsp_tdata[81:66]};
         results_seen++;
         if (hits_due.size() == 0) begin
            errors++;
            $display("%0t unexpected result %p", $realtime, got);
         end else begin
            want = hits_due.pop_front();
            if (got.hit != want.hit) begin
               errors++; $display("%0t hit exp %0d got %0d", $realtime, want.hit, got.hit);
            end
            if (got.x != want.x) begin
               errors++; $display("%0t hit_x exp %h got %h", $realtime, want.x, got.x);
            end
            if (got.y != want.y) begin
               errors++; $display("%0t hit_y exp %h got %h", $realtime, want.y, got.y);
            end
            if (got.sq != want.sq) begin
               errors++; $display("%0t sq exp %h got %h", $realtime, want.sq, got.sq);
            end
            if (got.ent != want.ent) begin
               errors++; $display("%0t entity exp %h got %h", $realtime, want.ent, got.ent);
            end
         end
      end
   end

   initial begin
      ray_ox = 0; ray_oy = 0; ray_dx = 16384; ray_dy = 0;
      ray_maxd = 16'hFFFF; ray_excl_en = 0; ray_excl_id = 0;
      clear_nearest();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      test_backpressure();
      wait_idle();
      $display("Sent %0d circles over many ray settings, checked %0d raycast results.",
               items_sent, results_seen);
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end
endmodule

[filelist.f]
src/crch_pkg.sv
src/crch_mul.sv
src/crch_isqrt.sv
src/closest_ray_circle_hit.sv
tb/tb_closest_ray_circle_hit.sv
